>>> hw/rtl/lfmq_pkg.sv
// ----------------------------------------------------------------------------
// lfmq_pkg
// Shared constants for the line framer and message queue.
// ----------------------------------------------------------------------------
package lfmq_pkg;

	localparam int LINE_LEN_DEF    = 128;
	localparam int QUEUE_DEPTH_DEF = 8;

	localparam logic [7:0] READ_LIMIT_RST = 8'd128;

	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_PRINT_LOW = 8'd32;
	localparam logic [7:0] CH_PRINT_HIGH = 8'd126;

	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_READ = 1'b1;

	typedef logic [2:0] event_t;

	localparam event_t EV_STORED     = 3'd0;
	localparam event_t EV_QUEUED     = 3'd1;
	localparam event_t EV_FULL       = 3'd2;
	localparam event_t EV_EMPTY_LINE = 3'd3;
	localparam event_t EV_OVERFLOW   = 3'd4;
	localparam event_t EV_IGNORED    = 3'd5;
	localparam event_t EV_CHAR       = 3'd6;
	localparam event_t EV_EMPTY_READ = 3'd7;

endpackage

>>> hw/rtl/lfmq_ram.sv
// ----------------------------------------------------------------------------
// lfmq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lfmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hw/rtl/line_framer_message_queue.sv
// ----------------------------------------------------------------------------
// line_framer_message_queue
// Assembles printable received bytes into lines and queues them for reading.
// ----------------------------------------------------------------------------
// Each transaction is taken on start while busy is low; busy is then high for
// the execute cycle, in which the line store and length memory return their
// registered read data and any write-back is made, and the result appears on
// the result ports for one cycle, flagged by done, in the cycle after that,
// while the next transaction may already be taken. No new transaction is taken
// while busy is high, as the line store's read data is registered. The
// receiver cannot hold results off: done is a single-cycle strobe and must be
// captured when it is seen. The memories need no clearing pass after reset, so
// the block is ready straight away.
module line_framer_message_queue
	import lfmq_pkg::*;
#(
	parameter int LINE_LEN    = LINE_LEN_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic       start,
	output logic       busy,
	input  logic       req_type,
	input  logic [7:0] rx_byte,
	output logic       done,
	output logic [2:0] event_res,
	output logic [6:0] out_char,
	output logic       last_of_message,
	output logic [3:0] message_count
);

	localparam int SLOTS = QUEUE_DEPTH + 1;
	localparam int SW    = $clog2(SLOTS);
	localparam int LW    = $clog2(LINE_LEN);
	localparam int CW    = $clog2(QUEUE_DEPTH + 1);
	localparam int DEPTH = SLOTS * LINE_LEN;
	localparam int AW    = $clog2(DEPTH);
	localparam int CMPW  = (LW > 8) ? LW : 8;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic          state_q;
	logic [7:0]    read_limit_q;
	logic [LW-1:0] asm_len_q;
	logic [SW-1:0] head_q;
	logic [SW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [LW-1:0] offset_q;

	logic       req_type_s1;
	logic [7:0] byte_s1;

	logic       done_q;
	event_t     event_q;
	logic [6:0] char_q;
	logic       last_q;
	logic [CW-1:0] count_out_q;

	logic          accept;
	logic          store_we;
	logic [AW-1:0] store_waddr;
	logic [AW-1:0] store_raddr;
	logic [6:0]    store_rdata;
	logic          len_we;
	logic [LW-1:0] len_rdata;

	// Next-state values worked out in the execute cycle.
	event_t        ev_d;
	logic [6:0]    char_d;
	logic          last_d;
	logic [LW-1:0] asm_len_d;
	logic [SW-1:0] head_d;
	logic [SW-1:0] tail_d;
	logic [CW-1:0] count_d;
	logic [LW-1:0] offset_d;
	logic [7:0]    lim;
	logic [CMPW-1:0] len_ext;
	logic [CMPW-1:0] lim_ext;
	logic [CMPW-1:0] eff;
	logic [CMPW-1:0] off_ext;
	logic [CMPW-1:0] off_new_ext;
	logic [LW-1:0]   off_new;
	logic            printable;
	logic [CW+3:0]   count_wide;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	assign store_raddr = AW'(head_q) * AW'(LINE_LEN) + AW'(offset_q);
	assign store_waddr = AW'(tail_q) * AW'(LINE_LEN) + AW'(asm_len_q);

	lfmq_ram #(
		.WIDTH (7),
		.DEPTH (DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (byte_s1[6:0]),
		.re    (accept),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	lfmq_ram #(
		.WIDTH (LW),
		.DEPTH (SLOTS)
	) u_slot_length (
		.clk   (clk),
		.we    (len_we),
		.waddr (tail_q),
		.wdata (asm_len_q),
		.re    (accept),
		.raddr (head_q),
		.rdata (len_rdata)
	);

	always_comb begin
		ev_d      = EV_IGNORED;
		char_d    = 7'd0;
		last_d    = 1'b0;
		asm_len_d = asm_len_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		offset_d  = offset_q;
		store_we  = 1'b0;
		len_we    = 1'b0;

		printable = (byte_s1 >= CH_PRINT_LOW) && (byte_s1 <= CH_PRINT_HIGH);
		lim       = (read_limit_q == 8'd0) ? 8'd0 : read_limit_q - 8'd1;
		len_ext   = CMPW'(len_rdata);
		lim_ext   = CMPW'(lim);
		eff       = (len_ext < lim_ext) ? len_ext : lim_ext;
		off_ext   = CMPW'(offset_q);
		off_new   = (off_ext < eff) ? offset_q + LW'(1) : offset_q;
		off_new_ext = CMPW'(off_new);

		if (state_q == ST_EXEC) begin
			if (req_type_s1 == REQ_BYTE) begin
				if (byte_s1 == CH_NEWLINE) begin
					asm_len_d = '0;
					if (asm_len_q == '0) begin
						ev_d = EV_EMPTY_LINE;
					end else if (count_q >= CW'(QUEUE_DEPTH)) begin
						ev_d = EV_FULL;
					end else begin
						ev_d    = EV_QUEUED;
						len_we  = 1'b1;
						tail_d  = (tail_q == SW'(SLOTS - 1)) ? '0 : tail_q + SW'(1);
						count_d = count_q + CW'(1);
					end
				end else if (printable) begin
					if (asm_len_q < LW'(LINE_LEN - 1)) begin
						ev_d      = EV_STORED;
						store_we  = 1'b1;
						asm_len_d = asm_len_q + LW'(1);
					end else begin
						ev_d      = EV_OVERFLOW;
						asm_len_d = '0;
					end
				end
			end else if (count_q == '0) begin
				ev_d = EV_EMPTY_READ;
			end else begin
				ev_d = EV_CHAR;
				if (off_ext < eff) begin
					char_d = store_rdata;
				end
				if (off_new_ext >= eff) begin
					// Line fully delivered: pop it from the ring.
					last_d   = 1'b1;
					offset_d = '0;
					head_d   = (head_q == SW'(SLOTS - 1)) ? '0 : head_q + SW'(1);
					count_d  = count_q - CW'(1);
				end else begin
					offset_d = off_new;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			read_limit_q <= READ_LIMIT_RST;
			asm_len_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			offset_q     <= '0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				read_limit_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			asm_len_q <= asm_len_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			count_q   <= count_d;
			offset_q  <= offset_d;
			done_q    <= (state_q == ST_EXEC);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req_type;
			byte_s1     <= rx_byte;
		end
		if (state_q == ST_EXEC) begin
			event_q     <= ev_d;
			char_q      <= char_d;
			last_q      <= last_d;
			count_out_q <= count_d;
		end
	end

	assign count_wide      = {4'd0, count_out_q};
	assign done            = done_q;
	assign event_res       = event_q;
	assign out_char        = char_q;
	assign last_of_message = last_q;
	assign message_count   = count_wide[3:0];

endmodule
